/* design/bavg_pkg.sv */
package bavg_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS  = 2'd3;

    localparam logic [12:0] RST_SRC_WIDTH  = 13'd320;
    localparam logic [12:0] RST_SRC_HEIGHT = 13'd240;
    localparam logic [8:0]  RST_GRID_COLS  = 9'd80;
    localparam logic [8:0]  RST_GRID_ROWS  = 9'd23;

    // Divider and accumulator widths
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 6;

    // Divider operand select
    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] SEL_RED   = 3'd0;
    localparam logic [SEL_W-1:0] SEL_GREEN = 3'd1;
    localparam logic [SEL_W-1:0] SEL_BLUE  = 3'd2;
    localparam logic [SEL_W-1:0] SEL_COL   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_ROW   = 3'd4;

    // One column accumulator entry
    typedef struct packed {
        logic [DIV_W-1:0] red;
        logic [DIV_W-1:0] green;
        logic [DIV_W-1:0] blue;
        logic [DIV_W-1:0] count;
    } acc_t;

    // Controller to datapath
    typedef struct packed {
        logic             take;
        logic             restart;
        logic             rd;
        logic             acc;
        logic             div_load;
        logic             div_start;
        logic             div_store;
        logic             load_out;
        logic             upd;
        logic [SEL_W-1:0] sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic accepted;
        logic frame_start;
        logic close_now;
        logic row_end;
        logic last_row;
        logic col_close;
        logic row_close;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

/* design/bavg_if.sv */
interface bavg_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_start;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_start,
                    output ready);
endinterface

interface bavg_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
    logic       frame_done;

    modport source (output valid, cell_x, cell_y, avg_red, avg_green, avg_blue,
                    frame_done, input ready);
    modport sink   (input valid, cell_x, cell_y, avg_red, avg_green, avg_blue,
                    frame_done, output ready);
endinterface

/* design/bavg_div.sv */
module bavg_div
    import bavg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W:0]       trial;

    // One restoring step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start && !busy_reg)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(DIV_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start && !busy_reg)
        begin
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* design/bavg_ctrl.sv */
module bavg_ctrl
    import bavg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RS    = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_DLOAD = 4'd4;
    localparam logic [3:0] S_DGO   = 4'd5;
    localparam logic [3:0] S_DWAIT = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;
    logic             pend_reg, pend_next;
    logic             need_row_reg, need_row_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        pend_next     = pend_reg;
        need_row_next = need_row_reg;
        cmd           = '0;
        cmd.sel       = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.accepted)
                begin
                    if (sts.frame_start)
                    begin
                        pend_next  = 1'b1;
                        state_next = S_RS;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RS:
            begin
                cmd.restart   = 1'b1;
                sel_next      = SEL_COL;
                need_row_next = 1'b1;
                state_next    = S_DLOAD;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                if (sts.close_now)
                begin
                    sel_next   = SEL_RED;
                    state_next = S_DLOAD;
                end
                else
                begin
                    state_next = S_UPD;
                end
            end
            S_DLOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = S_DGO;
            end
            S_DGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_store = 1'b1;
                    case (sel_reg)
                        SEL_RED:
                        begin
                            sel_next   = SEL_GREEN;
                            state_next = S_DLOAD;
                        end
                        SEL_GREEN:
                        begin
                            sel_next   = SEL_BLUE;
                            state_next = S_DLOAD;
                        end
                        SEL_BLUE:
                        begin
                            state_next = S_OUT;
                        end
                        SEL_COL:
                        begin
                            if (need_row_reg)
                            begin
                                sel_next   = SEL_ROW;
                                state_next = S_DLOAD;
                            end
                            else
                            begin
                                state_next = pend_reg ? S_RD : S_IDLE;
                                pend_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = pend_reg ? S_RD : S_IDLE;
                            pend_next  = 1'b0;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd   = 1'b1;
                pend_next = 1'b0;
                if (sts.row_end && sts.last_row)
                begin
                    state_next = S_RS;
                end
                else if (sts.row_end)
                begin
                    need_row_next = sts.row_close;
                    sel_next      = SEL_COL;
                    state_next    = S_DLOAD;
                end
                else if (sts.col_close)
                begin
                    need_row_next = 1'b0;
                    sel_next      = SEL_COL;
                    state_next    = S_DLOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            sel_reg      <= SEL_RED;
            pend_reg     <= 1'b0;
            need_row_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sel_reg      <= sel_next;
            pend_reg     <= pend_next;
            need_row_reg <= need_row_next;
        end
    end

endmodule

/* design/bavg_dp.sv */
module bavg_dp
    import bavg_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = 4096,
    parameter int MAX_SOURCE_HEIGHT = 4096,
    parameter int MAX_GRID_COLS     = 256,
    parameter int MAX_GRID_ROWS     = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bavg_pix_if.sink              pix,
    bavg_cell_if.source           tile,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts
);

    localparam int XW  = $clog2(MAX_SOURCE_WIDTH + 1);
    localparam int YW  = $clog2(MAX_SOURCE_HEIGHT + 1);
    localparam int CW  = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int RW  = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
    localparam int CNW = $clog2(MAX_GRID_COLS + 1);
    localparam int RNW = $clog2(MAX_GRID_ROWS + 1);

    // Configuration registers
    logic [12:0] src_w_reg, src_h_reg;
    logic [8:0]  grid_c_reg, grid_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg  <= RST_SRC_WIDTH;
            src_h_reg  <= RST_SRC_HEIGHT;
            grid_c_reg <= RST_GRID_COLS;
            grid_r_reg <= RST_GRID_ROWS;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SRC_WIDTH:  src_w_reg  <= cfg_data;
                REG_SRC_HEIGHT: src_h_reg  <= cfg_data;
                REG_GRID_COLS:  grid_c_reg <= cfg_data[8:0];
                REG_GRID_ROWS:  grid_r_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Clamped working sizes, zero reads as one
    logic [XW-1:0]  w;
    logic [YW-1:0]  h;
    logic [CNW-1:0] c;
    logic [RNW-1:0] r;

    assign w = (src_w_reg == '0) ? XW'(1) :
               (32'(src_w_reg) > MAX_SOURCE_WIDTH) ? XW'(MAX_SOURCE_WIDTH) : XW'(src_w_reg);
    assign h = (src_h_reg == '0) ? YW'(1) :
               (32'(src_h_reg) > MAX_SOURCE_HEIGHT) ? YW'(MAX_SOURCE_HEIGHT) : YW'(src_h_reg);
    assign c = (grid_c_reg == '0) ? CNW'(1) :
               (32'(grid_c_reg) > MAX_GRID_COLS) ? CNW'(MAX_GRID_COLS) : CNW'(grid_c_reg);
    assign r = (grid_r_reg == '0) ? RNW'(1) :
               (32'(grid_r_reg) > MAX_GRID_ROWS) ? RNW'(MAX_GRID_ROWS) : RNW'(grid_r_reg);

    // Position state
    logic [XW-1:0] src_x_reg, col_edge_reg;
    logic [YW-1:0] src_y_reg, row_edge_reg;
    logic [CW-1:0] cur_col_reg, col_reg;
    logic [RW-1:0] cur_row_reg, row_reg;

    // Pixel capture
    logic [7:0] pr_reg, pg_reg, pb_reg;
    logic       accepted;

    assign pix.ready = cmd.take;
    assign accepted  = cmd.take && pix.valid;

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            pr_reg <= pix.pixel_red;
            pg_reg <= pix.pixel_green;
            pb_reg <= pix.pixel_blue;
        end
    end

    // Column accumulator memory and valid bits
    acc_t                     mem [MAX_GRID_COLS];
    acc_t                     rd_data_reg;
    logic [MAX_GRID_COLS-1:0] valid_reg;
    logic [CW-1:0]            col_c;
    logic [RW-1:0]            row_c;

    assign col_c = (32'(cur_col_reg) < 32'(c)) ? cur_col_reg : CW'(32'(c) - 1);
    assign row_c = (32'(cur_row_reg) < 32'(r)) ? cur_row_reg : RW'(32'(r) - 1);

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[col_c];
            col_reg     <= col_c;
            row_reg     <= row_c;
        end
    end

    // Accumulate and close decisions
    acc_t entry, sum_next;
    logic row_end_c, last_row_c, col_close_c, row_close_c;

    always_comb
    begin
        entry          = valid_reg[col_reg] ? rd_data_reg : '0;
        sum_next.red   = entry.red   + DIV_W'(pr_reg);
        sum_next.green = entry.green + DIV_W'(pg_reg);
        sum_next.blue  = entry.blue  + DIV_W'(pb_reg);
        sum_next.count = entry.count + 1'b1;
        row_end_c      = (32'(src_x_reg) + 1) >= 32'(w);
        last_row_c     = (32'(src_y_reg) + 1) >= 32'(h);
        col_close_c    = row_end_c  || ((32'(src_x_reg) + 1) >= 32'(col_edge_reg));
        row_close_c    = last_row_c || ((32'(src_y_reg) + 1) >= 32'(row_edge_reg));
    end

    acc_t sum_reg;
    logic row_end_reg, last_row_reg, col_close_reg, row_close_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            mem[col_reg]  <= sum_next;
            sum_reg       <= sum_next;
            row_end_reg   <= row_end_c;
            last_row_reg  <= last_row_c;
            col_close_reg <= col_close_c;
            row_close_reg <= row_close_c;
        end
    end

    // Shared divider operands
    logic [DIV_W-1:0] dvd_reg, dvs_reg, quotient;
    logic             div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            case (cmd.sel)
                SEL_RED:
                begin
                    dvd_reg <= sum_reg.red;
                    dvs_reg <= sum_reg.count;
                end
                SEL_GREEN:
                begin
                    dvd_reg <= sum_reg.green;
                    dvs_reg <= sum_reg.count;
                end
                SEL_BLUE:
                begin
                    dvd_reg <= sum_reg.blue;
                    dvs_reg <= sum_reg.count;
                end
                SEL_COL:
                begin
                    dvd_reg <= DIV_W'((32'(cur_col_reg) + 1) * 32'(w));
                    dvs_reg <= DIV_W'(c);
                end
                default:
                begin
                    dvd_reg <= DIV_W'((32'(cur_row_reg) + 1) * 32'(h));
                    dvs_reg <= DIV_W'(r);
                end
            endcase
        end
    end

    bavg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Quotients: channel means
    logic [7:0] avg_r_reg, avg_g_reg, avg_b_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.sel)
                SEL_RED:   avg_r_reg <= quotient[7:0];
                SEL_GREEN: avg_g_reg <= quotient[7:0];
                SEL_BLUE:  avg_b_reg <= quotient[7:0];
                default: ;
            endcase
        end
    end

    // Position, edge and valid-bit update
    logic [DIV_W-1:0] col_nxt, row_nxt;

    assign col_nxt = 32'(col_reg) + 1;
    assign row_nxt = 32'(row_reg) + 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_x_reg    <= '0;
            src_y_reg    <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            col_edge_reg <= XW'(4);
            row_edge_reg <= YW'(10);
            valid_reg    <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                src_x_reg   <= '0;
                src_y_reg   <= '0;
                cur_col_reg <= '0;
                cur_row_reg <= '0;
                valid_reg   <= '0;
            end
            else if (cmd.acc)
            begin
                valid_reg[col_reg] <= !(col_close_c && row_close_c);
            end
            else if (cmd.upd)
            begin
                if (row_end_reg)
                begin
                    src_x_reg   <= '0;
                    cur_col_reg <= '0;
                    if (!last_row_reg)
                    begin
                        src_y_reg <= src_y_reg + 1'b1;
                        if (row_close_reg)
                        begin
                            valid_reg   <= '0;
                            cur_row_reg <= (row_nxt < 32'(r)) ? RW'(row_nxt)
                                                              : RW'(32'(r) - 1);
                        end
                    end
                end
                else
                begin
                    if (col_close_reg)
                    begin
                        cur_col_reg <= (col_nxt < 32'(c)) ? CW'(col_nxt)
                                                          : CW'(32'(c) - 1);
                    end
                    src_x_reg <= src_x_reg + 1'b1;
                end
            end
            else if (cmd.div_store && cmd.sel == SEL_COL)
            begin
                col_edge_reg <= (quotient <= 32'(src_x_reg)) ? XW'(32'(src_x_reg) + 1)
                                                             : XW'(quotient);
            end
            else if (cmd.div_store && cmd.sel == SEL_ROW)
            begin
                row_edge_reg <= (quotient <= 32'(src_y_reg)) ? YW'(32'(src_y_reg) + 1)
                                                             : YW'(quotient);
            end
        end
    end

    // Output register
    logic       out_valid_reg;
    logic [7:0] ox_reg, oy_reg, or_reg, og_reg, ob_reg;
    logic       odone_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || tile.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (tile.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ox_reg    <= 8'(col_reg);
            oy_reg    <= 8'(row_reg);
            or_reg    <= avg_r_reg;
            og_reg    <= avg_g_reg;
            ob_reg    <= avg_b_reg;
            odone_reg <= row_end_reg && last_row_reg;
        end
    end

    assign tile.valid      = out_valid_reg;
    assign tile.cell_x     = ox_reg;
    assign tile.cell_y     = oy_reg;
    assign tile.avg_red    = or_reg;
    assign tile.avg_green  = og_reg;
    assign tile.avg_blue   = ob_reg;
    assign tile.frame_done = odone_reg;

    // Status to controller
    always_comb
    begin
        sts             = '0;
        sts.accepted    = accepted;
        sts.frame_start = pix.frame_start;
        sts.close_now   = col_close_c && row_close_c;
        sts.row_end     = row_end_reg;
        sts.last_row    = last_row_reg;
        sts.col_close   = col_close_reg;
        sts.row_close   = row_close_reg;
        sts.div_done    = div_done;
        sts.out_free    = out_free;
    end

    // Checks
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |-> (32'(col_reg) < 32'(c)))
        else $error("column index past grid");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (sum_reg.count != '0))
        else $error("cell emitted with zero pixels");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && col_close_c && row_close_c) |=> !valid_reg[$past(col_reg)])
        else $error("closed column not cleared");

    a_col_edge_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_store && cmd.sel == SEL_COL) |=> (col_edge_reg > src_x_reg))
        else $error("column edge not past position");

endmodule

/* design/box_average_downscaler.sv */
// Channel   Dir  Handshake          Payload
// pix       in   valid/ready        pixel_red, pixel_green, pixel_blue, frame_start
// tile      out  valid/ready        cell_x, cell_y, avg_red, avg_green, avg_blue, frame_done
// cfg       in   cfg_we (no stall)  cfg_idx, cfg_data
//
// A pixel that closes no block passes through accept, memory read, accumulate and update.
// Closing a cell adds three divides on the shared serial divider plus an output load.
// Each recomputed block edge costs one divide on the same divider; a frame start or frame
// end recomputes both edges. The shared divider is a 32-step serial restoring divider.
// Reset is asynchronous, active low; sums clear at once through per-column valid bits.
// A full output register stalls the controller before the position update.
module box_average_downscaler
    import bavg_pkg::*;
#(
    parameter int MAX_SOURCE_WIDTH  = 4096,
    parameter int MAX_SOURCE_HEIGHT = 4096,
    parameter int MAX_GRID_COLS     = 256,
    parameter int MAX_GRID_ROWS     = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bavg_pix_if.sink              pix,
    bavg_cell_if.source           tile,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    bavg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bavg_dp #(
        .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
        .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
        .MAX_GRID_COLS     (MAX_GRID_COLS),
        .MAX_GRID_ROWS     (MAX_GRID_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .tile     (tile),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
